/* design/gic_pkg.sv */
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types and constants for the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int MAP_LEN    = 14;
    localparam int STEP_COUNT = 16;
    localparam int CNT_W      = 4;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [15:0] STICK_DZ_RESET  = 16'd15729;
    localparam logic [15:0] TRIG_TH_RESET   = 16'd7710;

    // Configuration register indexes.
    localparam logic [7:0] REG_STICK_DZ = 8'd0;
    localparam logic [7:0] REG_TRIG_TH  = 8'd1;

    // Raw button bit for each output bit, in output order.
    localparam logic [15:0] BUTTON_BITS [MAP_LEN] = '{
        16'h1000, 16'h2000, 16'h4000, 16'h8000,
        16'h0001, 16'h0002, 16'h0004, 16'h0008,
        16'h0100, 16'h0200, 16'h0040, 16'h0080,
        16'h0010, 16'h0020
    };

    // What the back end does with a poll.
    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_UPDATE,
        CLS_DROP
    } cls_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SQ_X,
        BK_SQ_Y,
        BK_SQRT,
        BK_CALC1,
        BK_CALC2,
        BK_DIV,
        BK_STORE,
        BK_TRIG,
        BK_TDIV,
        BK_TSTORE,
        BK_FIN
    } bk_state_t;

    typedef struct packed {
        cls_t        cls;
        logic        link;
        logic [15:0] buttons;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [7:0]  lt;
        logic [7:0]  rt;
    } gic_item_t;

    typedef struct packed {
        logic [13:0] down_mask;
        logic [13:0] pressed_mask;
        logic [13:0] released_mask;
        logic [15:0] left_out_x;
        logic [15:0] left_out_y;
        logic [15:0] right_out_x;
        logic [15:0] right_out_y;
        logic [15:0] left_trigger_out;
        logic [15:0] right_trigger_out;
        logic        link_up;
        logic        any_activity;
        logic        rumble_stop;
    } gic_result_t;

    function automatic logic [13:0] map_buttons(input logic [15:0] word, input int n);
        logic [13:0] mask;
        mask = '0;
        for (int i = 0; i < MAP_LEN; i++)
        begin
            if (i < n && (word & BUTTON_BITS[i]) != 16'h0)
            begin
                mask[i] = 1'b1;
            end
        end
        return mask;
    endfunction

endpackage

/* design/gic_front.sv */
// ----------------------------------------------------------------------------
// gic_front
// Accepts polls, tracks the link and retry counter, and classifies each poll.
// ----------------------------------------------------------------------------
module gic_front #(
    parameter int POLL_RETRY_INTERVAL = 60
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              q_full,
    input  logic              present,
    input  logic [15:0]       buttons,
    input  logic [15:0]       lx,
    input  logic [15:0]       ly,
    input  logic [15:0]       rx,
    input  logic [15:0]       ry,
    input  logic [7:0]        lt,
    input  logic [7:0]        rt,
    output logic              in_ready,
    output logic              push,
    output gic_pkg::gic_item_t item
);

    localparam int RW = $clog2(POLL_RETRY_INTERVAL + 1);

    logic          link_reg, link_next;
    logic [RW-1:0] retry_reg, retry_next;
    logic [RW-1:0] retry_inc;
    logic          look;

    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;
    assign retry_inc = retry_reg + 1'b1;

    always_comb
    begin
        look       = 1'b1;
        retry_next = retry_reg;
        link_next  = link_reg;
        item.cls   = gic_pkg::CLS_SKIP;
        if (!link_reg)
        begin
            if (retry_inc >= RW'(POLL_RETRY_INTERVAL))
            begin
                retry_next = '0;
            end
            else
            begin
                look       = 1'b0;
                retry_next = retry_inc;
            end
        end
        if (look && present)
        begin
            link_next = 1'b1;
            item.cls  = gic_pkg::CLS_UPDATE;
        end
        else if (look && link_reg)
        begin
            link_next = 1'b0;
            item.cls  = gic_pkg::CLS_DROP;
        end
        item.link    = link_next;
        item.buttons = buttons;
        item.lx      = lx;
        item.ly      = ly;
        item.rx      = rx;
        item.ry      = ry;
        item.lt      = lt;
        item.rt      = rt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg  <= 1'b0;
            retry_reg <= '0;
        end
        else if (push)
        begin
            link_reg  <= link_next;
            retry_reg <= retry_next;
        end
    end

endmodule

/* design/gic_queue.sv */
// ----------------------------------------------------------------------------
// gic_queue
// Two-entry queue of classified polls between the front and back ends.
// ----------------------------------------------------------------------------
module gic_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gic_pkg::gic_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               valid,
    output gic_pkg::gic_item_t head
);

    gic_pkg::gic_item_t              mem [gic_pkg::Q_DEPTH];
    logic [gic_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [gic_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [gic_pkg::Q_CNT_W-1:0]     count_reg;

    assign full  = count_reg == gic_pkg::Q_CNT_W'(gic_pkg::Q_DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/gic_back.sv */
// ----------------------------------------------------------------------------
// gic_back
// Sequenced arithmetic for one poll: stick magnitude, deadzone remap and
// trigger remap on a shared square root unit and a two-lane divider.
// ----------------------------------------------------------------------------
module gic_back #(
    parameter int BUTTONS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          stick_dz,
    input  logic [15:0]          trig_th,
    input  logic                 q_valid,
    input  gic_pkg::gic_item_t   q_head,
    output logic                 q_pop,
    input  logic                 out_ready,
    output logic                 out_valid,
    output gic_pkg::gic_result_t out_result
);

    gic_pkg::bk_state_t state_reg, state_next;
    gic_pkg::gic_item_t item_reg;

    logic [13:0] held_reg, prior_reg;
    logic [15:0] stick_reg [4];
    logic [15:0] trig_reg [2];
    logic        job_reg;
    logic [gic_pkg::CNT_W-1:0] cnt_reg;

    logic [31:0] s_reg;
    logic [15:0] root_reg;
    logic [17:0] srem_reg;
    logic        zero_reg, cap_reg;
    logic [31:0] num_reg;
    logic [16:0] den_reg;
    logic [32:0] div_reg;
    logic [32:0] rema_reg, remb_reg;
    logic [15:0] quoa_reg, quob_reg;
    logic [1:0]  tz_reg, tovf_reg;
    logic        ovalid_reg;
    gic_pkg::gic_result_t result_reg;

    // Stick operands of the current job.
    logic [15:0] x, y, ax, ay, sq_op;
    logic [31:0] sq;
    assign x     = job_reg ? item_reg.rx : item_reg.lx;
    assign y     = job_reg ? item_reg.ry : item_reg.ly;
    assign ax    = x[15] ? (~x + 16'd1) : x;
    assign ay    = y[15] ? (~y + 16'd1) : y;
    assign sq_op = (state_reg == gic_pkg::BK_SQ_X) ? ax : ay;
    assign sq    = sq_op * sq_op;

    // One square root step: two radicand bits in, one root bit out.
    logic [19:0] rem2;
    logic [17:0] trial;
    logic        sq_ge;
    assign rem2  = {srem_reg, s_reg[31:30]};
    assign trial = {root_reg, 2'b01};
    assign sq_ge = rem2 >= {2'b00, trial};

    // Deadzone terms.
    logic [31:0] dz, m65, num, capv;
    logic [16:0] den;
    assign dz   = ({16'h0, stick_dz} << 15) - {16'h0, stick_dz};
    assign m65  = {root_reg, 16'h0};
    assign num  = m65 - dz;
    assign den  = 17'h10000 - {1'b0, stick_dz};
    assign capv = ({15'h0, den} << 15) - {15'h0, den};

    // Remap products.
    logic [47:0] prod_a, prod_b, cap_a, cap_b;
    logic [32:0] mden;
    assign prod_a = {32'h0, ax} * {16'h0, num_reg};
    assign prod_b = {32'h0, ay} * {16'h0, num_reg};
    assign cap_a  = ({32'h0, ax} << 15) - {32'h0, ax};
    assign cap_b  = ({32'h0, ay} << 15) - {32'h0, ay};
    assign mden   = {17'h0, root_reg} * {16'h0, den_reg};

    // Trigger terms.
    logic [23:0] th, ra, rb, diffa, diffb;
    logic [16:0] tden;
    logic [24:0] tdiv;
    assign th    = ({8'h0, trig_th} << 8) - {8'h0, trig_th};
    assign tden  = 17'h10000 - {1'b0, trig_th};
    assign tdiv  = ({8'h0, tden} << 8) - {8'h0, tden};
    assign ra    = {item_reg.lt, 16'h0};
    assign rb    = {item_reg.rt, 16'h0};
    assign diffa = ra - th;
    assign diffb = rb - th;

    // Two-lane restoring divider step with a shared divisor.
    logic [33:0] r2a, r2b, sa, sb;
    logic        gea, geb;
    assign r2a = {rema_reg, quoa_reg[15]};
    assign r2b = {remb_reg, quob_reg[15]};
    assign gea = r2a >= {1'b0, div_reg};
    assign geb = r2b >= {1'b0, div_reg};
    assign sa  = r2a - {1'b0, div_reg};
    assign sb  = r2b - {1'b0, div_reg};

    logic [15:0] qx, qy, vx, vy;
    assign qx = zero_reg ? 16'h0 : quoa_reg;
    assign qy = zero_reg ? 16'h0 : quob_reg;
    assign vx = x[15] ? (~qx + 16'd1) : qx;
    assign vy = y[15] ? (~qy + 16'd1) : qy;

    logic fin_go;
    assign fin_go = (state_reg == gic_pkg::BK_FIN) && (!ovalid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            gic_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = (q_head.cls == gic_pkg::CLS_UPDATE) ?
                                 gic_pkg::BK_SQ_X : gic_pkg::BK_FIN;
                end
            end
            gic_pkg::BK_SQ_X:  state_next = gic_pkg::BK_SQ_Y;
            gic_pkg::BK_SQ_Y:  state_next = gic_pkg::BK_SQRT;
            gic_pkg::BK_SQRT:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = gic_pkg::BK_CALC1;
                end
            end
            gic_pkg::BK_CALC1: state_next = gic_pkg::BK_CALC2;
            gic_pkg::BK_CALC2: state_next = gic_pkg::BK_DIV;
            gic_pkg::BK_DIV:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = gic_pkg::BK_STORE;
                end
            end
            gic_pkg::BK_STORE:
            begin
                state_next = job_reg ? gic_pkg::BK_TRIG : gic_pkg::BK_SQ_X;
            end
            gic_pkg::BK_TRIG:  state_next = gic_pkg::BK_TDIV;
            gic_pkg::BK_TDIV:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = gic_pkg::BK_TSTORE;
                end
            end
            gic_pkg::BK_TSTORE: state_next = gic_pkg::BK_FIN;
            gic_pkg::BK_FIN:
            begin
                if (fin_go)
                begin
                    state_next = gic_pkg::BK_IDLE;
                end
            end
            default: state_next = gic_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gic_pkg::BK_IDLE;
            ovalid_reg <= 1'b0;
            held_reg   <= '0;
            prior_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                stick_reg[i] <= '0;
            end
            trig_reg[0] <= '0;
            trig_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == gic_pkg::BK_IDLE && q_valid)
            begin
                prior_reg <= held_reg;
                if (q_head.cls == gic_pkg::CLS_UPDATE)
                begin
                    held_reg <= gic_pkg::map_buttons(q_head.buttons, BUTTONS);
                end
                else if (q_head.cls == gic_pkg::CLS_DROP)
                begin
                    held_reg <= '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        stick_reg[i] <= '0;
                    end
                    trig_reg[0] <= '0;
                    trig_reg[1] <= '0;
                end
            end
            if (state_reg == gic_pkg::BK_STORE)
            begin
                stick_reg[{job_reg, 1'b0}] <= vx;
                stick_reg[{job_reg, 1'b1}] <= vy;
            end
            if (state_reg == gic_pkg::BK_TSTORE)
            begin
                trig_reg[0] <= tz_reg[0] ? 16'h0 : (tovf_reg[0] ? 16'hFFFF : quoa_reg);
                trig_reg[1] <= tz_reg[1] ? 16'h0 : (tovf_reg[1] ? 16'hFFFF : quob_reg);
            end
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gic_pkg::BK_IDLE:
            begin
                item_reg <= q_head;
                job_reg  <= 1'b0;
            end
            gic_pkg::BK_SQ_X:
            begin
                s_reg <= sq;
            end
            gic_pkg::BK_SQ_Y:
            begin
                s_reg    <= s_reg + sq;
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            gic_pkg::BK_SQRT:
            begin
                s_reg    <= s_reg << 2;
                srem_reg <= sq_ge ? 18'(rem2 - {2'b00, trial}) : rem2[17:0];
                root_reg <= {root_reg[14:0], sq_ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            gic_pkg::BK_CALC1:
            begin
                zero_reg <= (root_reg == 16'h0) || (m65 < dz);
                num_reg  <= num;
                den_reg  <= den;
                cap_reg  <= num >= capv;
            end
            gic_pkg::BK_CALC2:
            begin
                cnt_reg <= '0;
                if (cap_reg)
                begin
                    div_reg  <= {17'h0, root_reg};
                    rema_reg <= {1'b0, cap_a[47:16]};
                    quoa_reg <= cap_a[15:0];
                    remb_reg <= {1'b0, cap_b[47:16]};
                    quob_reg <= cap_b[15:0];
                end
                else
                begin
                    div_reg  <= mden;
                    rema_reg <= {1'b0, prod_a[47:16]};
                    quoa_reg <= prod_a[15:0];
                    remb_reg <= {1'b0, prod_b[47:16]};
                    quob_reg <= prod_b[15:0];
                end
            end
            gic_pkg::BK_DIV, gic_pkg::BK_TDIV:
            begin
                rema_reg <= gea ? sa[32:0] : r2a[32:0];
                remb_reg <= geb ? sb[32:0] : r2b[32:0];
                quoa_reg <= {quoa_reg[14:0], gea};
                quob_reg <= {quob_reg[14:0], geb};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            gic_pkg::BK_STORE:
            begin
                job_reg <= 1'b1;
            end
            gic_pkg::BK_TRIG:
            begin
                cnt_reg     <= '0;
                div_reg     <= {8'h0, tdiv};
                tz_reg[0]   <= ra < th;
                tz_reg[1]   <= rb < th;
                tovf_reg[0] <= {1'b0, diffa} >= tdiv;
                tovf_reg[1] <= {1'b0, diffb} >= tdiv;
                rema_reg    <= {9'h0, diffa};
                remb_reg    <= {9'h0, diffb};
                quoa_reg    <= '0;
                quob_reg    <= '0;
            end
            default:
            begin
            end
        endcase
        if (fin_go)
        begin
            result_reg.down_mask         <= held_reg;
            result_reg.pressed_mask      <= held_reg & ~prior_reg;
            result_reg.released_mask     <= prior_reg & ~held_reg;
            result_reg.left_out_x        <= stick_reg[0];
            result_reg.left_out_y        <= stick_reg[1];
            result_reg.right_out_x       <= stick_reg[2];
            result_reg.right_out_y       <= stick_reg[3];
            result_reg.left_trigger_out  <= trig_reg[0];
            result_reg.right_trigger_out <= trig_reg[1];
            result_reg.link_up           <= item_reg.link;
            result_reg.any_activity      <= item_reg.link &&
                ((held_reg != '0) || (trig_reg[0] != '0) || (trig_reg[1] != '0) ||
                 (stick_reg[0] != '0) || (stick_reg[1] != '0) ||
                 (stick_reg[2] != '0) || (stick_reg[3] != '0));
            result_reg.rumble_stop       <= item_reg.cls == gic_pkg::CLS_DROP;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_result = result_reg;

endmodule

/* design/gamepad_input_conditioner_core.sv */
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_core
// Conditions controller polls: button edges, radial stick deadzone with
// rescale, trigger threshold remap, and link tracking with retry polling.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                          Transaction
// s_*       in         s_tvalid s_tready s_tdata s_tuser one controller poll
// m_*       out        m_tvalid m_tready m_tdata         one conditioned poll
// cfg_*     in         cfg_valid cfg_ready cfg_index     one register write
//                      cfg_data
//
// Each poll produces exactly one output transaction. An updating poll holds the
// back end through, per stick, a 16-step square root and a 16-step two-lane
// division with their setup states, then a 16-step trigger division with its
// setup and store states, and one state each to pop and to finish. A two-entry
// queue keeps the input open while the back end works or a result waits on
// m_tready. Reset (rst_n, asynchronous) sets the link down, the retry count,
// masks, sticks and triggers to zero. The configuration port is always ready.
module gamepad_input_conditioner_core #(
    parameter int BUTTONS             = 14,
    parameter int POLL_RETRY_INTERVAL = 60
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: button_word[15:0], left_axis_x[31:16],
    // left_axis_y[47:32], right_axis_x[63:48], right_axis_y[79:64],
    // left_trigger_raw[87:80], right_trigger_raw[95:88]
    input  logic [95:0]  s_tdata,
    // s_tuser: sample_present
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: down_mask[13:0], pressed_mask[27:14],
    // released_mask[41:28], left_out_x[57:42], left_out_y[73:58],
    // right_out_x[89:74], right_out_y[105:90], left_trigger_out[121:106],
    // right_trigger_out[137:122], link_up[138], any_activity[139],
    // rumble_stop[140], zero fill[143:141]
    output logic [143:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    // Configuration registers. Writes to unknown indexes are dropped.
    logic [15:0] stick_dz_reg;
    logic [15:0] trig_th_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_dz_reg <= gic_pkg::STICK_DZ_RESET;
            trig_th_reg  <= gic_pkg::TRIG_TH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == gic_pkg::REG_STICK_DZ)
            begin
                stick_dz_reg <= cfg_data;
            end
            else if (cfg_index == gic_pkg::REG_TRIG_TH)
            begin
                trig_th_reg <= cfg_data;
            end
        end
    end

    // Front end: link state, retry counting and classification.
    logic               push, q_full, q_valid, q_pop;
    gic_pkg::gic_item_t push_item, q_head;

    gic_front #(
        .POLL_RETRY_INTERVAL(POLL_RETRY_INTERVAL)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .q_full   (q_full),
        .present  (s_tuser),
        .buttons  (s_tdata[15:0]),
        .lx       (s_tdata[31:16]),
        .ly       (s_tdata[47:32]),
        .rx       (s_tdata[63:48]),
        .ry       (s_tdata[79:64]),
        .lt       (s_tdata[87:80]),
        .rt       (s_tdata[95:88]),
        .in_ready (s_tready),
        .push     (push),
        .item     (push_item)
    );

    gic_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Back end: arithmetic sequencer and the output register.
    gic_pkg::gic_result_t res;

    gic_back #(
        .BUTTONS(BUTTONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stick_dz   (stick_dz_reg),
        .trig_th    (trig_th_reg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (res)
    );

    assign m_tdata = {3'b000, res.rumble_stop, res.any_activity, res.link_up,
                      res.right_trigger_out, res.left_trigger_out,
                      res.right_out_y, res.right_out_x, res.left_out_y, res.left_out_x,
                      res.released_mask, res.pressed_mask, res.down_mask};

    // A rumble stop is only sent on the poll that takes the link down.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[140] |-> !m_tdata[138])
        else $error("rumble_stop with link up");

    // Activity is only reported while connected.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[139] |-> m_tdata[138])
        else $error("any_activity without link");

    // A button cannot be pressed and released on the same poll.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[27:14] & m_tdata[41:28]) == 14'h0)
        else $error("pressed and released overlap");

    // The queue never takes a poll while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_tready)
        else $error("poll accepted into a full queue");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gamepad input conditioner core. A clocked driver
// takes polls from a queue and sends them on the slave stream with random gaps.
// Every accepted poll runs through a behavioral conditioner model that keeps
// its own link, retry, button and deadzone state. A monitor compares each
// output transaction with the oldest predicted poll result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RETRY = 60;

    // One poll as the driver sends it.
    typedef struct {
        logic        present;
        logic [15:0] buttons;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [7:0]  lt;
        logic [7:0]  rt;
        int          gap;
        logic        is_cfg;
        logic [7:0]  cfg_idx;
        logic [15:0] cfg_val;
    } poll_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [15:0]  cfg_data;

    gamepad_input_conditioner_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Model state of the conditioner.
    logic [15:0] deadzone    = gic_pkg::STICK_DZ_RESET;
    logic [15:0] threshold   = gic_pkg::TRIG_TH_RESET;
    logic        link_model  = 1'b0;
    int          retry_model = 0;
    logic [13:0] held_model  = '0;
    logic [15:0] stick_model [4] = '{default: '0};
    logic [15:0] trig_model [2]  = '{default: '0};

    poll_t                poll_queue [$];
    gic_pkg::gic_result_t expected_results [$];

    int    mismatches    = 0;
    int    results_seen  = 0;
    int    polls_sent    = 0;
    int    taken_count   = 0;
    int    handled_count = 0;
    int    wait_left     = 0;
    int    rx_seen       = 0;
    int    rx_wait       = 0;
    bit    have_item     = 1'b0;
    bit    hold_off      = 1'b0;
    bit    stream_done   = 1'b0;
    poll_t cur_poll;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scaled radial deadzone on one stick; writes the two conditioned axes.
    task automatic shape_stick(input logic [15:0] xr, input logic [15:0] yr,
                               output logic [15:0] ox, output logic [15:0] oy);
        longint signed   x;
        longint signed   y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        longint unsigned dz;
        longint unsigned num;
        longint unsigned den;
        longint unsigned qx;
        longint unsigned qy;
        x  = longint'($signed(xr));
        y  = longint'($signed(yr));
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m  = root_floor(ax * ax + ay * ay);
        dz = longint'(deadzone) * 32767;
        if (m == 0 || m * 65536 < dz)
        begin
            ox = '0;
            oy = '0;
        end
        else
        begin
            num = m * 65536 - dz;
            den = 65536 - longint'(deadzone);
            if (num >= 32767 * den)
            begin
                qx = (32767 * ax) / m;
                qy = (32767 * ay) / m;
            end
            else
            begin
                qx = (ax * num) / (m * den);
                qy = (ay * num) / (m * den);
            end
            ox = x < 0 ? 16'(-qx) : 16'(qx);
            oy = y < 0 ? 16'(-qy) : 16'(qy);
        end
    endtask

    function automatic logic [15:0] shape_trigger(input logic [7:0] raw);
        longint unsigned th;
        longint unsigned q;
        th = longint'(threshold) * 255;
        if (longint'(raw) * 65536 < th)
            return '0;
        q = ((longint'(raw) * 65536 - th) * 65536) / (255 * (65536 - longint'(threshold)));
        return q > 65535 ? 16'hFFFF : 16'(q);
    endfunction

    // Advances the model by one accepted poll and queues its conditioned result.
    task automatic condition_poll(input poll_t p);
        gic_pkg::gic_result_t r;
        logic [13:0] prior;
        logic        look;
        logic        stop;
        logic        busy;
        prior = held_model;
        look  = 1'b1;
        stop  = 1'b0;
        if (!link_model)
        begin
            retry_model++;
            if (retry_model < RETRY)
                look = 1'b0;
            else
                retry_model = 0;
        end
        if (look && p.present)
        begin
            link_model = 1'b1;
            held_model = '0;
            for (int i = 0; i < gic_pkg::MAP_LEN; i++)
                if ((p.buttons & gic_pkg::BUTTON_BITS[i]) != 16'h0)
                    held_model[i] = 1'b1;
            shape_stick(p.lx, p.ly, stick_model[0], stick_model[1]);
            shape_stick(p.rx, p.ry, stick_model[2], stick_model[3]);
            trig_model[0] = shape_trigger(p.lt);
            trig_model[1] = shape_trigger(p.rt);
        end
        else if (look && link_model)
        begin
            link_model = 1'b0;
            held_model = '0;
            for (int i = 0; i < 4; i++)
                stick_model[i] = '0;
            trig_model[0] = '0;
            trig_model[1] = '0;
            stop = 1'b1;
        end
        busy = held_model != 0 || trig_model[0] != 0 || trig_model[1] != 0 ||
               stick_model[0] != 0 || stick_model[1] != 0 ||
               stick_model[2] != 0 || stick_model[3] != 0;
        r.down_mask         = held_model;
        r.pressed_mask      = held_model & ~prior;
        r.released_mask     = prior & ~held_model;
        r.left_out_x        = stick_model[0];
        r.left_out_y        = stick_model[1];
        r.right_out_x       = stick_model[2];
        r.right_out_y       = stick_model[3];
        r.left_trigger_out  = trig_model[0];
        r.right_trigger_out = trig_model[1];
        r.link_up           = link_model;
        r.any_activity      = link_model && busy;
        r.rumble_stop       = stop;
        expected_results.push_back(r);
    endtask

    // Puts a result into the m_tdata field layout, lowest field first.
    function automatic logic [140:0] pack_result(input gic_pkg::gic_result_t r);
        return {r.rumble_stop, r.any_activity, r.link_up,
                r.right_trigger_out, r.left_trigger_out,
                r.right_out_y, r.right_out_x, r.left_out_y, r.left_out_x,
                r.released_mask, r.pressed_mask, r.down_mask};
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 2000)) - 16'd1000;
            3: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic poll_t make_poll(input logic present, input int max_gap);
        poll_t p;
        p.present = present;
        p.buttons = 16'($urandom);
        p.lx      = rand_axis();
        p.ly      = rand_axis();
        p.rx      = rand_axis();
        p.ry      = rand_axis();
        p.lt      = 8'($urandom);
        p.rt      = 8'($urandom);
        p.gap     = $urandom_range(0, max_gap);
        p.is_cfg  = 1'b0;
        p.cfg_idx = gic_pkg::REG_STICK_DZ;
        p.cfg_val = '0;
        return p;
    endfunction

    // A register write, carried through the same queue so it lands only
    // once the block has drained.
    function automatic poll_t make_write(input logic [7:0] idx, input logic [15:0] val);
        poll_t p;
        p         = make_poll(1'b0, 0);
        p.is_cfg  = 1'b1;
        p.cfg_idx = idx;
        p.cfg_val = val;
        return p;
    endfunction

    // Enough absent polls to bring the retry counter round to a look.
    task automatic add_connect(input int max_gap);
        for (int i = 0; i < RETRY - 1; i++)
            poll_queue.push_back(make_poll(1'b0, max_gap));
    endtask

    // Roughly every fiftieth slot holds a reconnect sequence so a dropped
    // link comes back up soon and most polls are looked at.
    function automatic bit link_state_hint(input int k);
        return (k % 50) == 49;
    endfunction

    // Records every accepted transaction on the input and configuration
    // channels and advances the model with it.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            condition_poll(cur_poll);
            polls_sent++;
            taken_count++;
        end
        else if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == gic_pkg::REG_STICK_DZ)
                deadzone = cfg_data;
            else if (cfg_index == gic_pkg::REG_TRIG_TH)
                threshold = cfg_data;
            taken_count++;
        end
    end

    // Driver: one queue entry per transaction, with a random gap before each poll.
    // Register writes wait until every expected result has come back.
    always @(negedge clk)
    begin
        logic tv;
        logic cv;
        tv = s_tvalid;
        cv = cfg_valid;
        if (!rst_n)
        begin
            tv = 1'b0;
            cv = 1'b0;
            s_tuser   <= 1'b0;
            s_tdata   <= '0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (taken_count != handled_count)
            begin
                handled_count = taken_count;
                tv        = 1'b0;
                cv        = 1'b0;
                have_item = 1'b0;
            end
            if (!have_item && poll_queue.size() != 0)
            begin
                cur_poll  = poll_queue.pop_front();
                have_item = 1'b1;
                wait_left = cur_poll.is_cfg ? 100 : cur_poll.gap;
            end
            if (have_item && !tv && !cv)
            begin
                if (cur_poll.is_cfg && expected_results.size() != 0)
                    wait_left = 100;
                else if (wait_left != 0)
                    wait_left--;
                else if (cur_poll.is_cfg)
                begin
                    cv = 1'b1;
                    cfg_index <= cur_poll.cfg_idx;
                    cfg_data  <= cur_poll.cfg_val;
                end
                else
                begin
                    tv = 1'b1;
                    s_tuser <= cur_poll.present;
                    s_tdata <= {cur_poll.rt, cur_poll.lt, cur_poll.ry, cur_poll.rx,
                                cur_poll.ly, cur_poll.lx, cur_poll.buttons};
                end
            end
            if (!have_item)
                stream_done = 1'b1;
        end
        s_tvalid  <= tv;
        cfg_valid <= cv;
    end

    // One long receiver hold-off while polls keep coming, so the input queue
    // fills and backs up.
    initial
    begin
        wait (polls_sent >= 300);
        hold_off = 1'b1;
        repeat (2000)
            @(posedge clk);
        hold_off = 1'b0;
    end

    // Receiver: holds m_tready low for a randomly drawn wait after every output transaction.
    always @(negedge clk)
    begin
        if (results_seen != rx_seen)
        begin
            rx_seen = results_seen;
            rx_wait = $urandom_range(0, 15);
        end
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else if (rx_wait != 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: compares each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        gic_pkg::gic_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output transaction: %h", m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== {3'b000, pack_result(want)})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on result %0d: expected %h, actual %h",
                                 results_seen, {3'b000, pack_result(want)}, m_tdata);
                end
            end
        end
    end

    initial
    begin
        poll_t p;

        // Directed part: connect, then the field extremes under reset settings.
        add_connect(0);
        p = make_poll(1'b1, 0);
        p.buttons = 16'hFFFF; p.lx = 16'h8000; p.ly = 16'h8000;
        p.rx = 16'h7FFF; p.ry = 16'h7FFF; p.lt = 8'hFF; p.rt = 8'hFF;
        poll_queue.push_back(p);
        p = make_poll(1'b1, 0);
        p.buttons = 16'h0000; p.lx = '0; p.ly = '0; p.rx = 16'h0100; p.ry = '0;
        p.lt = 8'h00; p.rt = 8'h08;
        poll_queue.push_back(p);
        p = make_poll(1'b1, 2);
        p.buttons = 16'hAAAA; p.lx = 16'h7FFF; p.ly = '0; p.rx = '0; p.ry = 16'h8001;
        poll_queue.push_back(p);
        // Dropped sample while connected, then a missing one while down.
        poll_queue.push_back(make_poll(1'b0, 1));
        poll_queue.push_back(make_poll(1'b0, 1));

        // Zero deadzone with a centered stick, and full threshold.
        poll_queue.push_back(make_write(gic_pkg::REG_STICK_DZ, 16'h0000));
        poll_queue.push_back(make_write(gic_pkg::REG_TRIG_TH, 16'hFFFF));
        add_connect(0);
        p = make_poll(1'b1, 0);
        p.lx = '0; p.ly = '0; p.lt = 8'hFF; p.rt = 8'hFE;
        poll_queue.push_back(p);
        p = make_poll(1'b1, 0);
        p.buttons = 16'h5555;
        poll_queue.push_back(p);

        // Random phases, each under its own register setting. Out-of-range
        // indexes must be ignored.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: poll_queue.push_back(make_write(gic_pkg::REG_STICK_DZ, 16'hFFFF));
                1: poll_queue.push_back(make_write(gic_pkg::REG_TRIG_TH, 16'h0000));
                2: poll_queue.push_back(make_write(8'hFF, 16'h1234));
                3: poll_queue.push_back(make_write(gic_pkg::REG_STICK_DZ,
                                                   gic_pkg::STICK_DZ_RESET));
                default:
                begin
                    poll_queue.push_back(make_write(gic_pkg::REG_STICK_DZ, 16'($urandom)));
                    poll_queue.push_back(make_write(gic_pkg::REG_TRIG_TH, 16'($urandom)));
                end
            endcase
            for (int k = 0; k < 70; k++)
            begin
                if (!link_state_hint(k))
                    poll_queue.push_back(make_poll($urandom_range(0, 39) != 0,
                                                   (k % 30 < 8) ? 0 : 15));
                else
                    add_connect(($urandom_range(0, 1) == 0) ? 0 : 15);
            end
        end

        // Hold rst_n low, then let the driver go.
        rst_n = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (stream_done);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        $display("Covered %0d polls and %0d results across link drops, reconnects,",
                 polls_sent, results_seen);
        $display("stalls and deadzone and threshold settings from zero to full scale.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* gamepad_input_conditioner_core.f */
design/gic_pkg.sv
design/gic_front.sv
design/gic_queue.sv
design/gic_back.sv
design/gamepad_input_conditioner_core.sv
tb/sv/tb_top.sv
